// File: hdl/cba_pkg.sv
// Package for the chained bump allocator: transaction payload types,
// result status codes, controller states and the alignment helper.
// No dependencies.
`default_nettype none

package cba_pkg;

    // Configuration port geometry and register addresses.
    localparam int unsigned CfgAddrW = 3;
    localparam logic [CfgAddrW-1:0] ADDR_CHUNK_SIZE = 3'd0;
    localparam logic [15:0] CHUNK_SIZE_RESET = 16'd4096;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        ACT_TAKE  = 1'b0,
        ACT_RESET = 1'b1
    } t_action;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WALK = 1'b1
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] request_size;
        logic [12:0] alignment;
    } t_alloc_req;

    typedef struct packed {
        t_status     status;
        logic [3:0]  chunk_index;
        logic [15:0] start_offset;
    } t_alloc_rsp;

    // Mask of the largest power of two not above the alignment, less one.
    // An alignment of zero behaves as one, giving an empty mask.
    function automatic logic [12:0] align_mask(input logic [12:0] a);
        logic [12:0] m;
        m = '0;
        for (int i = 0; i < 13; i++) begin
            if (a[i]) begin
                m = 13'((14'd1 << i) - 14'd1);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/chained_bump_allocator_unit.sv
// Chained bump allocator, top level: walk controller, fill-offset memory
// and the configuration register port. Depends on cba_pkg.
// A take accepted while idle walks one chunk per cycle; a grant or failure
// decided at a chunk is registered onto o_done, and busy stays high until
// the walk has decided, falling as o_done rises. A reset action answers
// on o_done without raising busy. The receiver cannot stall. i_rst_n
// (synchronous) empties every chunk, leaves one chunk open and sets
// chunk_size to 4096.
`default_nettype none

module chained_bump_allocator_unit
    import cba_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS  = 16,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Command channel.
    input  wire logic                start,
    input  wire t_alloc_req          i_req,
    output logic                     busy,
    // Result channel.
    output logic                     o_done,
    output t_alloc_rsp               o_rsp,
    // Configuration port.
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [CfgAddrW-1:0] paddr,
    input  wire logic [31:0]         pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    // Index width of the chunk memory and width of the open-chunk count.
    localparam int unsigned IdxW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int unsigned CntW = $clog2(MAX_CHUNKS + 1);
    // Arithmetic width: room for an offset, a rounding carry and a size.
    localparam int unsigned SumW = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;
    localparam logic [SumW-1:0] OffMax = SumW'((64'd1 << OFFSET_BITS) - 64'd1);

    // ------------------------------------------------------------------
    // Configuration register. Writes must arrive only while the block is idle; the block does not enforce it.
    // ------------------------------------------------------------------
    logic [15:0] r_chunk_size;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CHUNK_SIZE);
    assign prdata = (paddr == ADDR_CHUNK_SIZE) ? {16'd0, r_chunk_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= CHUNK_SIZE_RESET;
        end else if (cfg_wr) begin
            r_chunk_size <= pwdata[15:0];
        end
    end

    // ------------------------------------------------------------------
    // Fill-offset memory. One synchronous read port and one write port.
    // Each entry carries a valid bit in flip-flops: an entry that is not
    // valid reads as an empty chunk, so a reset action or the opening of
    // a chunk only has to clear valid bits.
    // ------------------------------------------------------------------
    logic [OFFSET_BITS-1:0] mem [MAX_CHUNKS];
    logic [OFFSET_BITS-1:0] r_rdata;
    logic [IdxW-1:0]        rd_addr;
    logic                   mem_we;
    logic [OFFSET_BITS-1:0] mem_wdata;
    logic [IdxW-1:0]        r_idx, n_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= mem_wdata;
        end
        r_rdata <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Walk controller.
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [MAX_CHUNKS-1:0] r_valid, n_valid;
    logic [CntW-1:0]      r_open, n_open;
    logic                 r_done, n_done;
    t_alloc_rsp           r_rsp, n_rsp;
    logic [15:0]          r_size, n_size;
    logic [12:0]          r_mask, n_mask;

    logic                 accept;
    logic [SumW-1:0]      fill;
    logic [SumW-1:0]      aligned;
    logic [SumW-1:0]      fill_end;
    logic [SumW-1:0]      limit;
    logic                 last_open;
    logic [31:0]          idx_wide;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Datapath for the chunk whose offset is on the read port this cycle.
    always_comb begin
        fill      = r_valid[r_idx] ? SumW'(r_rdata) : '0;
        aligned   = (fill + SumW'(r_mask)) & ~SumW'(r_mask);
        fill_end  = aligned + SumW'(r_size);
        // The usable size saturates to what an offset can hold.
        limit     = (SumW'(r_chunk_size) < OffMax) ? SumW'(r_chunk_size) : OffMax;
        last_open = (32'(r_idx) + 32'd1) >= 32'(r_open);
        idx_wide  = 32'(r_idx);
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_valid   = r_valid;
        n_open    = r_open;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_size    = r_size;
        n_mask    = r_mask;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_wdata = fill_end[OFFSET_BITS-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.action == ACT_RESET) begin
                        // Empty every chunk; the open count is kept.
                        n_valid = '0;
                        n_done  = 1'b1;
                        n_rsp   = '{status: ST_OK, chunk_index: '0, start_offset: '0};
                    end else begin
                        // Start the walk at the first chunk.
                        n_state = S_WALK;
                        n_idx   = '0;
                        rd_addr = '0;
                        n_size  = i_req.request_size;
                        n_mask  = align_mask(i_req.alignment);
                    end
                end
            end
            S_WALK: begin
                priority if (fill_end <= limit) begin
                    // Granted: bump this chunk's offset past the allocation.
                    mem_we            = 1'b1;
                    n_valid[r_idx]    = 1'b1;
                    n_done            = 1'b1;
                    n_rsp.status       = ST_OK;
                    n_rsp.chunk_index  = idx_wide[3:0];
                    n_rsp.start_offset = aligned[15:0];
                    n_state           = S_IDLE;
                end else if (fill == '0) begin
                    // Even an empty chunk cannot hold the request.
                    n_done  = 1'b1;
                    n_rsp   = '{status: ST_NOFIT, chunk_index: '0, start_offset: '0};
                    n_state = S_IDLE;
                end else if (last_open && (r_open >= CntW'(MAX_CHUNKS))) begin
                    // Every chunk is in use and none had room.
                    n_done  = 1'b1;
                    n_rsp   = '{status: ST_FULL, chunk_index: '0, start_offset: '0};
                    n_state = S_IDLE;
                end else begin
                    // Move on; past the last chunk in use a fresh one is opened.
                    if (last_open) begin
                        n_valid[r_open[IdxW-1:0]] = 1'b0;
                        n_open                    = r_open + CntW'(1);
                    end
                    n_idx   = r_idx + IdxW'(1);
                    rd_addr = r_idx + IdxW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_open  <= CntW'(1);
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_open  <= n_open;
            r_done  <= n_done;
            r_idx   <= n_idx;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_rsp  <= n_rsp;
        r_size <= n_size;
        r_mask <= n_mask;
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

`default_nettype wire

// File: tb/sv/tb_chained_bump_allocator_unit.sv
// Self-checking testbench for chained_bump_allocator_unit: directed and random
// take/clear transactions, chunk-size changes over APB, and a scoreboard class.
// Depends on cba_pkg and the allocator RTL only.

module tb_chained_bump_allocator_unit;
    import cba_pkg::*;

    localparam int unsigned NUM_CHUNKS  = 16;
    localparam int unsigned OFFSET_W    = 16;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned NUM_PHASES  = 10;
    localparam int unsigned PHASE_ITEMS = 130;

    // Scoreboard: keeps its own copy of the chunk chain and predicts the
    // response of every accepted request transaction.
    class alloc_scoreboard;
        int unsigned chunk_bytes;
        int unsigned fill_level[NUM_CHUNKS];
        int unsigned open_chunks;
        t_alloc_rsp  awaited_rsp[$];
        int unsigned mismatches;
        int unsigned grants;
        int unsigned no_fits;
        int unsigned chain_fulls;
        int unsigned clears;

        function new();
            chunk_bytes = CHUNK_SIZE_RESET;
            foreach (fill_level[k]) fill_level[k] = 0;
            open_chunks = 1;
            mismatches  = 0;
            grants      = 0;
            no_fits     = 0;
            chain_fulls = 0;
            clears      = 0;
        endfunction

        function void set_chunk_size(logic [15:0] value);
            chunk_bytes = value;
        endfunction

        // Works out the response of one accepted request and updates the chain.
        function void allocate(t_alloc_req r);
            t_alloc_rsp  rsp;
            int unsigned align_bytes;
            int unsigned usable;
            int unsigned aligned;
            int unsigned idx;
            bit          settled;
            rsp.status       = ST_OK;
            rsp.chunk_index  = '0;
            rsp.start_offset = '0;
            usable = (chunk_bytes < (1 << OFFSET_W) - 1) ? chunk_bytes : (1 << OFFSET_W) - 1;
            // Largest power of two not above the alignment; zero counts as one.
            align_bytes = 1;
            for (int b = 0; b < 13; b++) begin
                if (r.alignment[b]) align_bytes = 1 << b;
            end
            if (r.action == ACT_RESET) begin
                foreach (fill_level[k]) fill_level[k] = 0;
                clears++;
            end else begin
                idx     = 0;
                settled = 1'b0;
                while (!settled) begin
                    aligned = (fill_level[idx] + align_bytes - 1) & ~(align_bytes - 1);
                    if (aligned + r.request_size <= usable) begin
                        fill_level[idx]  = aligned + r.request_size;
                        rsp.chunk_index  = 4'(idx);
                        rsp.start_offset = 16'(aligned);
                        grants++;
                        settled = 1'b1;
                    end else if (fill_level[idx] == 0) begin
                        rsp.status = ST_NOFIT;
                        no_fits++;
                        settled = 1'b1;
                    end else if (idx + 1 < open_chunks) begin
                        idx++;
                    end else if (open_chunks >= NUM_CHUNKS) begin
                        rsp.status = ST_FULL;
                        chain_fulls++;
                        settled = 1'b1;
                    end else begin
                        // Open a fresh chunk at the end of the chain and move on to it.
                        fill_level[open_chunks] = 0;
                        open_chunks++;
                        idx++;
                    end
                end
            end
            awaited_rsp.push_back(rsp);
        endfunction

        function void check_rsp(t_alloc_rsp got);
            t_alloc_rsp want;
            if (awaited_rsp.size() == 0) begin
                $display("%0t: unexpected response: status %0d chunk %0d offset %0d",
                         $time, got.status, got.chunk_index, got.start_offset);
                mismatches++;
                return;
            end
            want = awaited_rsp.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d, actual %0d",
                         $time, want.status, got.status);
                mismatches++;
            end
            if (got.chunk_index !== want.chunk_index) begin
                $display("%0t: chunk_index expected %0d, actual %0d",
                         $time, want.chunk_index, got.chunk_index);
                mismatches++;
            end
            if (got.start_offset !== want.start_offset) begin
                $display("%0t: start_offset expected %0d, actual %0d",
                         $time, want.start_offset, got.start_offset);
                mismatches++;
            end
        endfunction
    endclass

    // Every input holds a known value from time zero.
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    t_alloc_req          i_req   = '0;
    logic                busy;
    logic                o_done;
    t_alloc_rsp          o_rsp;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [CfgAddrW-1:0] paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    alloc_scoreboard sb = new();
    int unsigned     cfg_errors    = 0;
    int unsigned     idle_cycles   = 0;
    int unsigned     settings_used = 0;
    bit              steady_stream = 1'b0;

    chained_bump_allocator_unit #(
        .MAX_CHUNKS  (NUM_CHUNKS),
        .OFFSET_BITS (OFFSET_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // Response monitor. The strobe lasts one cycle and cannot be held off, so
    // every edge that sees o_done high completes a response transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_rsp(o_rsp);
        end
    end

    // Watchdog: a run that makes no progress for too long is a failure. Any
    // accepted request, response or APB access counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_chained_bump_allocator_unit: errors");
            $finish;
        end
    end

    function automatic t_alloc_req make_req(t_action act, int unsigned size,
                                            int unsigned align);
        t_alloc_req r;
        r.action       = act;
        r.request_size = 16'(size);
        r.alignment    = 13'(align);
        return r;
    endfunction

    // Random request shaped around the current chunk size, so that chains
    // fill up and the no-fit and chain-full paths are reached often. Clears
    // are rare enough to let a chain run full between them.
    function automatic t_alloc_req random_req(int unsigned cs);
        t_alloc_req  r;
        int unsigned pick;
        r.action       = ACT_TAKE;
        r.request_size = 16'($urandom);
        r.alignment    = 13'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            r.action = ACT_RESET;
        end else if (pick < 8) begin
            // Size stays fully random, mostly too large for a chunk.
        end else if (pick < 12) begin
            r.request_size = '0;
        end else if (pick < 70) begin
            r.request_size = 16'($urandom_range(1, cs / 4 + 1));
        end else begin
            r.request_size = 16'($urandom_range(0, cs / 2 + 1));
        end
        // Mostly clean powers of two, weighted towards small ones; the rest
        // keep the raw random value, which covers zero and non-powers.
        if ($urandom_range(0, 4) != 0) begin
            r.alignment = 13'(1) << $urandom_range(0, $urandom_range(0, 12));
        end
        return r;
    endfunction

    // Presents one request and returns at the edge that accepts it. When no
    // gap is drawn, start simply stays high into the next transaction.
    task automatic issue_request(input t_alloc_req r);
        int unsigned gap;
        gap = steady_stream ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.allocate(r);
    endtask

    // Lowers start and waits until every predicted response has come back.
    // Each request yields exactly one response, so the block is idle then.
    task automatic drain();
        start <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    // APB write of chunk_size followed straight away by a read-back. The
    // read starts with its own setup cycle right after the write's access.
    task automatic set_chunk_size(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CHUNK_SIZE;
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_chunk_size(value);
        settings_used++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[15:0] !== value) begin
            $display("%0t: chunk_size read-back expected %0d, actual %0d",
                     $time, value, prdata[15:0]);
            cfg_errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [15:0] cs_value;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, at the reset chunk size of 4096 bytes.
        issue_request(make_req(ACT_TAKE, 0, 1));        // empty request at offset 0
        issue_request(make_req(ACT_TAKE, 100, 0));      // zero alignment behaves as one
        issue_request(make_req(ACT_TAKE, 10, 4096));    // largest alignment opens chunk 1
        issue_request(make_req(ACT_TAKE, 0, 4096));     // empty request right at the end
        issue_request(make_req(ACT_TAKE, 1, 8191));     // non-power rounds down to 4096
        issue_request(make_req(ACT_TAKE, 65535, 1));    // too large: new chunk cannot fit
        issue_request(make_req(ACT_TAKE, 4096, 1));     // exact fit in that new chunk
        issue_request(make_req(ACT_RESET, 65535, 8191));
        // Fill the whole chain, one chunk per request, then overflow it.
        for (int n = 0; n <= NUM_CHUNKS; n++) begin
            issue_request(make_req(ACT_TAKE, 4000, 2));
        end
        issue_request(make_req(ACT_RESET, 0, 0));
        drain();

        // Random part: several chunk sizes including both extremes. The chain
        // is not cleared between phases, so a lowered size also meets chunks
        // that are already filled beyond it.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       cs_value = 16'hFFFF;
                1:       cs_value = 16'd0;
                2:       cs_value = 16'd1;
                3:       cs_value = 16'd64;
                4:       cs_value = 16'd4096;
                5:       cs_value = 16'd300;
                6:       cs_value = 16'h8000;
                7:       cs_value = 16'($urandom_range(1, 255));
                default: cs_value = 16'($urandom_range(1, 65535));
            endcase
            set_chunk_size(cs_value);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Runs of back-to-back requests alternate with gapped ones.
                if (n % 25 == 0) steady_stream = ($urandom_range(0, 3) == 0);
                issue_request(random_req(sb.chunk_bytes));
            end
            drain();
        end

        // Let any stray strobe show up before the verdict.
        repeat (NUM_CHUNKS + 4) @(posedge i_clk);
        if (sb.awaited_rsp.size() != 0) begin
            $display("%0t: %0d responses never arrived", $time, sb.awaited_rsp.size());
            cfg_errors++;
        end
        $display("Run covered %0d grants, %0d no-fit, %0d chain-full and %0d clears",
                 sb.grants, sb.no_fits, sb.chain_fulls, sb.clears);
        $display("over %0d chunk-size settings after the reset default.", settings_used);
        if (sb.mismatches == 0 && cfg_errors == 0) begin
            $display("tb_chained_bump_allocator_unit: clean");
        end else begin
            $display("tb_chained_bump_allocator_unit: errors");
        end
        $finish;
    end

endmodule
